@@ rtl/letter_ngram_histogram_top_defines.svh @@
// Assertion macros used by the letter n-gram histogram RTL.
`ifndef LETTER_NGRAM_HISTOGRAM_TOP_DEFINES_SVH
`define LETTER_NGRAM_HISTOGRAM_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds, outside reset.
`define LNH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("letter n-gram histogram check failed");

// Checks that cons holds in the cycle after ante holds, outside reset.
`define LNH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("letter n-gram histogram check failed");

`endif

@@ rtl/lnh_pkg.sv @@
// Types, constants and helper functions of the letter n-gram histogram.
package lnh_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int COUNT_WIDTH   = 32;
	localparam int LETTER_WIDTH  = 5;
	localparam int OUT_WIDTH     = 32;

	localparam int PAIR_CELLS   = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int TRIPLE_CELLS = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int LETTER_AW    = $clog2(ALPHABET_SIZE);
	localparam int PAIR_AW      = $clog2(PAIR_CELLS);
	localparam int TRIPLE_AW    = $clog2(TRIPLE_CELLS);

	localparam int RESULT_DEPTH = 3;
	localparam int RESULT_PW    = $clog2(RESULT_DEPTH);
	localparam int RESULT_CW    = $clog2(RESULT_DEPTH + 1);

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	typedef logic [COUNT_WIDTH-1:0]  count_t;
	typedef logic [LETTER_WIDTH-1:0] letter_t;

	typedef enum logic [1:0] {
		OP_FEED        = 2'd0,
		OP_READ_LETTER = 2'd1,
		OP_READ_PAIR   = 2'd2,
		OP_READ_TRIPLE = 2'd3
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] char_code;
		logic       starts_line;
		letter_t    first_letter;
		letter_t    second_letter;
		letter_t    third_letter;
	} item_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] read_count;
		logic [OUT_WIDTH-1:0] triple_total;
		logic [OUT_WIDTH-1:0] peak_count;
		letter_t              peak_first;
		letter_t              peak_second;
		letter_t              peak_third;
	} result_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

	function automatic logic letter_ok(input letter_t v);
		return {1'b0, v} < (LETTER_WIDTH + 1)'(ALPHABET_SIZE);
	endfunction

	function automatic logic [PAIR_AW-1:0] pair_index(input letter_t a, input letter_t b);
		return PAIR_AW'(a) * PAIR_AW'(ALPHABET_SIZE) + PAIR_AW'(b);
	endfunction

	function automatic logic [TRIPLE_AW-1:0] triple_index(input letter_t a, input letter_t b,
			input letter_t c);
		return TRIPLE_AW'(pair_index(a, b)) * TRIPLE_AW'(ALPHABET_SIZE) + TRIPLE_AW'(c);
	endfunction

endpackage

@@ rtl/letter_ngram_histogram_top.sv @@
// Top level of the letter n-gram histogram: address stage, counter update and result queue.
// Throughput: one request per cycle, with reads and feeds freely interleaved, as long as the
// output does not stall. Each request passes stage 1 and is then written to the result queue.
// The rate is set by the read-modify-write loop on the three counter RAMs, closed by forwarding.
// After reset the block clears all counter RAMs, one address per cycle over all TRIPLE_CELLS,
// and stalls requests until that pass is done; letter history and statistics reset at once.
module letter_ngram_histogram_top (
	input  logic            clk,
	input  logic            arst_n,
	input  lnh_pkg::item_t  item,
	input  logic            item_valid,
	output logic            item_stall,
	output lnh_pkg::result_t result,
	output logic            result_valid,
	input  logic            result_stall
);

	import lnh_pkg::*;

	`include "letter_ngram_histogram_top_defines.svh"

	// ------------------------------------------------------------------
	// Clearing pass. The triple store is the deepest, so the sweep runs
	// over its address range and the smaller stores take the low part.
	// ------------------------------------------------------------------
	logic                 clearing_q;
	logic [TRIPLE_AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == TRIPLE_AW'(TRIPLE_CELLS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + TRIPLE_AW'(1);
		end
	end

	// ------------------------------------------------------------------
	// Accept stage: map the byte, update the letter history and compute
	// the addresses. The history depends only on the byte stream, never on
	// counter values, so it is kept up to date at acceptance.
	// ------------------------------------------------------------------
	logic    item_accept;
	logic    older_valid_q, recent_valid_q;
	letter_t older_letter_q, recent_letter_q;
	logic    hist_older_valid, hist_recent_valid;
	letter_t hist_older, hist_recent;
	logic [7:0] mapped;
	logic       is_letter;
	letter_t    letter;
	logic       is_feed;

	assign item_accept = item_valid && !item_stall;
	assign is_feed     = (item.operation == OP_FEED);

	always_comb begin
		mapped    = (item.char_code > CHAR_UPPER_Z) ? item.char_code - CHAR_LOWER_A
		                                            : item.char_code - CHAR_UPPER_A;
		is_letter = mapped < 8'(ALPHABET_SIZE);
		letter    = mapped[LETTER_WIDTH-1:0];

		// A line start wipes the history before this byte, letter or not.
		hist_older_valid  = older_valid_q && !item.starts_line;
		hist_recent_valid = recent_valid_q && !item.starts_line;
		hist_older        = item.starts_line ? '0 : older_letter_q;
		hist_recent       = item.starts_line ? '0 : recent_letter_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_valid_q   <= 1'b0;
			recent_valid_q  <= 1'b0;
			older_letter_q  <= '0;
			recent_letter_q <= '0;
		end else if (item_accept && is_feed) begin
			if (is_letter) begin
				older_valid_q   <= hist_recent_valid;
				older_letter_q  <= hist_recent;
				recent_valid_q  <= 1'b1;
				recent_letter_q <= letter;
			end else begin
				older_valid_q   <= hist_older_valid;
				older_letter_q  <= hist_older;
				recent_valid_q  <= hist_recent_valid;
				recent_letter_q <= hist_recent;
			end
		end
	end

	// Read addresses: a feed uses the new letter and its history, a read
	// uses the requested letters. Out-of-range reads go to address zero and
	// their data is discarded.
	logic                 a_ok, ab_ok, abc_ok;
	logic [LETTER_AW-1:0] l_raddr;
	logic [PAIR_AW-1:0]   p_raddr;
	logic [TRIPLE_AW-1:0] t_raddr;

	always_comb begin
		a_ok   = letter_ok(item.first_letter);
		ab_ok  = a_ok && letter_ok(item.second_letter);
		abc_ok = ab_ok && letter_ok(item.third_letter);
		if (is_feed) begin
			l_raddr = is_letter ? LETTER_AW'(letter) : '0;
			p_raddr = is_letter ? pair_index(hist_recent, letter) : '0;
			t_raddr = is_letter ? triple_index(hist_older, hist_recent, letter) : '0;
		end else begin
			l_raddr = a_ok ? LETTER_AW'(item.first_letter) : '0;
			p_raddr = ab_ok ? pair_index(item.first_letter, item.second_letter) : '0;
			t_raddr = abc_ok ? triple_index(item.first_letter, item.second_letter,
			                                item.third_letter) : '0;
		end
	end

	// Stage 1 control and payload.
	logic                 s1_valid;
	op_t                  op_s1;
	logic                 idx_ok_s1;
	logic                 do_letter_s1, do_pair_s1, do_triple_s1;
	letter_t              t_first_s1, t_second_s1, t_third_s1;
	logic [LETTER_AW-1:0] l_addr_s1;
	logic [PAIR_AW-1:0]   p_addr_s1;
	logic [TRIPLE_AW-1:0] t_addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= item_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_s1        <= item.operation;
			do_letter_s1 <= is_feed && is_letter;
			do_pair_s1   <= is_feed && is_letter && hist_recent_valid;
			do_triple_s1 <= is_feed && is_letter && hist_recent_valid && hist_older_valid;
			t_first_s1   <= hist_older;
			t_second_s1  <= hist_recent;
			t_third_s1   <= letter;
			l_addr_s1    <= l_raddr;
			p_addr_s1    <= p_raddr;
			t_addr_s1    <= t_raddr;
			unique case (item.operation)
				OP_FEED:        idx_ok_s1 <= 1'b0;
				OP_READ_LETTER: idx_ok_s1 <= a_ok;
				OP_READ_PAIR:   idx_ok_s1 <= ab_ok;
				OP_READ_TRIPLE: idx_ok_s1 <= abc_ok;
				default:        idx_ok_s1 <= 1'b0;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Counter RAMs. Each is read-first, so a write in the same cycle as the
	// next request's read is invisible to it; the last write is therefore
	// held and forwarded in stage 1. Older writes are
	// already in the RAM when the read takes place.
	// ------------------------------------------------------------------
	count_t l_rdata, p_rdata, t_rdata;
	logic   l_we, p_we, t_we;
	logic [LETTER_AW-1:0] l_waddr;
	logic [PAIR_AW-1:0]   p_waddr;
	logic [TRIPLE_AW-1:0] t_waddr;
	count_t l_wdata, p_wdata, t_wdata;

	lnh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET_SIZE)) u_letter_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	lnh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PAIR_CELLS)) u_pair_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	lnh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TRIPLE_CELLS)) u_triple_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// Forwarding registers: the previous cycle's update of each store.
	logic                 l_fwd_q, p_fwd_q, t_fwd_q;
	logic [LETTER_AW-1:0] l_fwd_addr_q;
	logic [PAIR_AW-1:0]   p_fwd_addr_q;
	logic [TRIPLE_AW-1:0] t_fwd_addr_q;
	count_t               l_fwd_data_q, p_fwd_data_q, t_fwd_data_q;

	count_t l_cur, p_cur, t_cur;
	count_t l_new, p_new, t_new;
	logic   l_upd, p_upd, t_upd;

	always_comb begin
		l_cur = (l_fwd_q && l_fwd_addr_q == l_addr_s1) ? l_fwd_data_q : l_rdata;
		p_cur = (p_fwd_q && p_fwd_addr_q == p_addr_s1) ? p_fwd_data_q : p_rdata;
		t_cur = (t_fwd_q && t_fwd_addr_q == t_addr_s1) ? t_fwd_data_q : t_rdata;
		l_new = sat_inc(l_cur);
		p_new = sat_inc(p_cur);
		t_new = sat_inc(t_cur);
		l_upd = s1_valid && do_letter_s1;
		p_upd = s1_valid && do_pair_s1;
		t_upd = s1_valid && do_triple_s1;

		// During the clearing pass no request is in flight, so the sweep
		// owns the write ports.
		if (clearing_q) begin
			l_we    = clr_addr_q < TRIPLE_AW'(ALPHABET_SIZE);
			p_we    = clr_addr_q < TRIPLE_AW'(PAIR_CELLS);
			t_we    = 1'b1;
			l_waddr = clr_addr_q[LETTER_AW-1:0];
			p_waddr = clr_addr_q[PAIR_AW-1:0];
			t_waddr = clr_addr_q;
			l_wdata = '0;
			p_wdata = '0;
			t_wdata = '0;
		end else begin
			l_we    = l_upd;
			p_we    = p_upd;
			t_we    = t_upd;
			l_waddr = l_addr_s1;
			p_waddr = p_addr_s1;
			t_waddr = t_addr_s1;
			l_wdata = l_new;
			p_wdata = p_new;
			t_wdata = t_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_fwd_q <= 1'b0;
			p_fwd_q <= 1'b0;
			t_fwd_q <= 1'b0;
		end else begin
			l_fwd_q <= l_upd;
			p_fwd_q <= p_upd;
			t_fwd_q <= t_upd;
		end
	end

	always_ff @(posedge clk) begin
		l_fwd_addr_q <= l_addr_s1;
		p_fwd_addr_q <= p_addr_s1;
		t_fwd_addr_q <= t_addr_s1;
		l_fwd_data_q <= l_new;
		p_fwd_data_q <= p_new;
		t_fwd_data_q <= t_new;
	end

	// ------------------------------------------------------------------
	// Statistics: saturating triple total and the peak triple. The peak
	// only moves on a strictly larger count, so ties keep the first cell.
	// ------------------------------------------------------------------
	count_t  total_q, peak_count_q;
	letter_t peak_first_q, peak_second_q, peak_third_q;
	count_t  total_next, peak_next;
	letter_t peak_first_next, peak_second_next, peak_third_next;

	always_comb begin
		total_next       = total_q;
		peak_next        = peak_count_q;
		peak_first_next  = peak_first_q;
		peak_second_next = peak_second_q;
		peak_third_next  = peak_third_q;
		if (t_upd) begin
			total_next = sat_inc(total_q);
			if (t_new > peak_count_q) begin
				peak_next        = t_new;
				peak_first_next  = t_first_s1;
				peak_second_next = t_second_s1;
				peak_third_next  = t_third_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			peak_count_q  <= '0;
			peak_first_q  <= '0;
			peak_second_q <= '0;
			peak_third_q  <= '0;
		end else begin
			total_q       <= total_next;
			peak_count_q  <= peak_next;
			peak_first_q  <= peak_first_next;
			peak_second_q <= peak_second_next;
			peak_third_q  <= peak_third_next;
		end
	end

	// Result of the request in stage 1, with the statistics after it.
	result_t s1_result;
	count_t  read_value;

	always_comb begin
		read_value = '0;
		if (idx_ok_s1) begin
			unique case (op_s1)
				OP_FEED:        read_value = '0;
				OP_READ_LETTER: read_value = l_cur;
				OP_READ_PAIR:   read_value = p_cur;
				OP_READ_TRIPLE: read_value = t_cur;
				default:        read_value = '0;
			endcase
		end
		s1_result.read_count   = read_value[OUT_WIDTH-1:0];
		s1_result.triple_total = total_next[OUT_WIDTH-1:0];
		s1_result.peak_count   = peak_next[OUT_WIDTH-1:0];
		s1_result.peak_first   = peak_first_next;
		s1_result.peak_second  = peak_second_next;
		s1_result.peak_third   = peak_third_next;
	end

	// ------------------------------------------------------------------
	// Result queue. Stage 1 never holds, so the input is stalled whenever
	// the queue could not take what is already in flight. Three entries
	// keep one request a cycle flowing while the output is not stalled.
	// ------------------------------------------------------------------
	result_t                result_q [RESULT_DEPTH];
	logic [RESULT_PW-1:0]   head_q, tail_q;
	logic [RESULT_CW-1:0]   fill_q;
	logic                   pop;

	assign pop          = result_valid && !result_stall;
	assign result_valid = (fill_q != '0);
	assign result       = result_q[head_q];
	assign item_stall   = clearing_q ||
	                      ((RESULT_CW + 1)'(fill_q) + (RESULT_CW + 1)'(s1_valid)
	                       >= (RESULT_CW + 1)'(RESULT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (s1_valid) begin
				tail_q <= (tail_q == RESULT_PW'(RESULT_DEPTH - 1)) ? '0 : tail_q + RESULT_PW'(1);
			end
			if (pop) begin
				head_q <= (head_q == RESULT_PW'(RESULT_DEPTH - 1)) ? '0 : head_q + RESULT_PW'(1);
			end
			fill_q <= fill_q + RESULT_CW'(s1_valid) - RESULT_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			result_q[tail_q] <= s1_result;
		end
	end

	// ------------------------------------------------------------------
	// Checks on the internal logic.
	// ------------------------------------------------------------------
	`LNH_ASSERT_NOW(a_queue_bound, 1'b1, fill_q <= RESULT_CW'(RESULT_DEPTH))
	`LNH_ASSERT_NOW(a_no_request_in_clear, clearing_q, !item_accept && !s1_valid)
	`LNH_ASSERT_NEXT(a_peak_monotonic, 1'b1, peak_count_q >= $past(peak_count_q))
	`LNH_ASSERT_NEXT(a_total_only_on_triple, !t_upd, $stable(total_q))

endmodule

@@ rtl/lnh_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered, read-first output.
module lnh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ verif/tb_letter_ngram_histogram_top.sv @@
// Self-checking testbench of the letter n-gram histogram: feed and read requests against a predictor.
module tb_letter_ngram_histogram_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lnh_pkg::*;

	// The block clears its counter RAMs over all TRIPLE_CELLS addresses after reset and stalls
	// every request meanwhile, so the quiet-cycle limit must sit well above that pass.
	localparam int QUIET_LIMIT     = 100000;
	localparam int RANDOM_REQUESTS = 1150;
	localparam int DRAIN_CYCLES    = 8;

	logic    clk;
	logic    arst_n       = 1'b0;
	item_t   item_bus     = '0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	result_t result_bus;
	logic    result_valid;
	logic    result_stall = 1'b0;

	letter_ngram_histogram_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_bus),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result_bus),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	// Requests waiting to be driven, and the results that accepted requests must produce.
	item_t   pending_requests[$];
	result_t expected_results[$];

	// Predicted histograms and letter history of the block.
	count_t trigram_tally [TRIPLE_CELLS];
	count_t digram_tally  [PAIR_CELLS];
	count_t letter_tally  [ALPHABET_SIZE];
	int     older_idx;
	logic   older_known;
	int     recent_idx;
	logic   recent_known;
	count_t trigram_sum;
	count_t peak_tally;
	int     peak_idx;

	int     mismatches;
	int     quiet_cycles;
	logic   stuck;
	int     burst_left;
	int     gap_left;
	int     stall_mode;
	int     stall_phase;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Saturating increment: a counter that is full stays full.
	function automatic count_t bump(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

	// A letter index as a byte, in upper or lower case at random.
	function automatic logic [7:0] letter_char(input int idx);
		return ($urandom_range(0, 1) != 0) ? CHAR_LOWER_A + 8'(idx) : CHAR_UPPER_A + 8'(idx);
	endfunction

	// A feed request; the letter fields are unused by a feed, so they carry noise.
	function automatic item_t make_feed(input logic [7:0] code, input logic line_start);
		item_t it;
		it.operation     = OP_FEED;
		it.char_code     = code;
		it.starts_line   = line_start;
		it.first_letter  = letter_t'($urandom_range(0, 31));
		it.second_letter = letter_t'($urandom_range(0, 31));
		it.third_letter  = letter_t'($urandom_range(0, 31));
		return it;
	endfunction

	// A read request; the byte is unused by a read and carries noise.
	function automatic item_t make_read(input op_t op, input int a, input int b, input int c,
			input logic line_start);
		item_t it;
		it.operation     = op;
		it.char_code     = 8'($urandom_range(0, 255));
		it.starts_line   = line_start;
		it.first_letter  = letter_t'(a);
		it.second_letter = letter_t'(b);
		it.third_letter  = letter_t'(c);
		return it;
	endfunction

	// Applies one accepted request to the predicted state and queues the result it must give.
	task automatic tally_request(input item_t it);
		result_t    r;
		count_t     value;
		logic [7:0] rel;
		int         slot;
		value = '0;
		case (it.operation)
			OP_FEED: begin
				// A line start wipes the history even when the byte turns out not to be a letter.
				if (it.starts_line) begin
					older_known  = 1'b0;
					recent_known = 1'b0;
					older_idx    = 0;
					recent_idx   = 0;
				end
				// Bytes below the base wrap to large values and so fail the range test.
				rel = (it.char_code > CHAR_UPPER_Z) ? it.char_code - CHAR_LOWER_A
						: it.char_code - CHAR_UPPER_A;
				if (rel < ALPHABET_SIZE) begin
					if (older_known && recent_known) begin
						slot = (older_idx * ALPHABET_SIZE + recent_idx) * ALPHABET_SIZE + rel;
						trigram_tally[slot] = bump(trigram_tally[slot]);
						trigram_sum = bump(trigram_sum);
						// Only a strictly larger count moves the peak, so ties keep the first cell.
						if (trigram_tally[slot] > peak_tally) begin
							peak_tally = trigram_tally[slot];
							peak_idx   = slot;
						end
					end
					if (recent_known) begin
						slot = recent_idx * ALPHABET_SIZE + rel;
						digram_tally[slot] = bump(digram_tally[slot]);
					end
					letter_tally[rel] = bump(letter_tally[rel]);
					older_idx    = recent_idx;
					older_known  = recent_known;
					recent_idx   = rel;
					recent_known = 1'b1;
				end
			end
			// Any index beyond the alphabet reads as zero.
			OP_READ_LETTER: begin
				if (it.first_letter < ALPHABET_SIZE)
					value = letter_tally[it.first_letter];
			end
			OP_READ_PAIR: begin
				if (it.first_letter < ALPHABET_SIZE && it.second_letter < ALPHABET_SIZE)
					value = digram_tally[it.first_letter * ALPHABET_SIZE + it.second_letter];
			end
			default: begin
				if (it.first_letter < ALPHABET_SIZE && it.second_letter < ALPHABET_SIZE &&
						it.third_letter < ALPHABET_SIZE)
					value = trigram_tally[(it.first_letter * ALPHABET_SIZE + it.second_letter)
							* ALPHABET_SIZE + it.third_letter];
			end
		endcase
		r.read_count   = value;
		r.triple_total = trigram_sum;
		r.peak_count   = peak_tally;
		r.peak_first   = letter_t'(peak_idx / PAIR_CELLS);
		r.peak_second  = letter_t'((peak_idx / ALPHABET_SIZE) % ALPHABET_SIZE);
		r.peak_third   = letter_t'(peak_idx % ALPHABET_SIZE);
		expected_results.push_back(r);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Driver: requests go out in bursts of random length with random gaps between them.
	// A stalled request is held as it is until the block takes it.
	always @(posedge clk) begin
		if (arst_n && (!item_valid || !item_stall)) begin
			if (item_valid)
				tally_request(item_bus);
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				item_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				item_bus <= pending_requests.pop_front();
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// A quarter of bursts run straight on into the next with no gap.
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result stall: the pattern is redrawn at random, over and over, among no stall at all,
	// random stalls, and a fixed pattern that holds the result back for long runs.
	always @(posedge clk) begin
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			if (stall_phase % 200 == 199)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0:       result_stall <= 1'b0;
				1:       result_stall <= ($urandom_range(0, 99) < 40);
				default: result_stall <= (stall_phase % 16 < 11);
			endcase
		end
	end

	// Monitor: each accepted result is held against the oldest expectation, field by field.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: result expected none, got %p", $time, result_bus);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_count", want.read_count, result_bus.read_count);
				check_field("triple_total", want.triple_total, result_bus.triple_total);
				check_field("peak_count", want.peak_count, result_bus.peak_count);
				check_field("peak_first", 32'(want.peak_first), 32'(result_bus.peak_first));
				check_field("peak_second", 32'(want.peak_second), 32'(result_bus.peak_second));
				check_field("peak_third", 32'(want.peak_third), 32'(result_bus.peak_third));
			end
		end
	end

	// Watchdog: counts cycles in which neither a request nor a result is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT)
				stuck <= 1'b1;
		end
	end

	initial begin
		int   pick;
		int   sel;
		int   a;
		int   b;
		int   c;
		op_t  op;
		logic [7:0] code;

		mismatches   = 0;
		quiet_cycles = 0;
		stuck        = 1'b0;
		burst_left   = 0;
		gap_left     = 0;
		stall_mode   = 0;
		stall_phase  = 0;
		foreach (trigram_tally[i])
			trigram_tally[i] = '0;
		foreach (digram_tally[i])
			digram_tally[i] = '0;
		foreach (letter_tally[i])
			letter_tally[i] = '0;
		older_idx    = 0;
		older_known  = 1'b0;
		recent_idx   = 0;
		recent_known = 1'b0;
		trigram_sum  = '0;
		peak_tally   = '0;
		peak_idx     = 0;

		// Directed part. Reads of the empty histograms, including indices past the alphabet.
		pending_requests.push_back(make_read(OP_READ_LETTER, 0, 0, 0, 1'b0));
		pending_requests.push_back(make_read(OP_READ_TRIPLE, 25, 25, 25, 1'b1));
		pending_requests.push_back(make_read(OP_READ_LETTER, 31, 31, 31, 1'b0));
		// "ABC" with the extreme bytes between the letters; they are skipped and keep the history.
		pending_requests.push_back(make_feed(CHAR_UPPER_A, 1'b1));
		pending_requests.push_back(make_feed(8'h00, 1'b0));
		pending_requests.push_back(make_feed(CHAR_UPPER_A + 8'd1, 1'b0));
		pending_requests.push_back(make_feed(8'hFF, 1'b0));
		pending_requests.push_back(make_feed(CHAR_UPPER_A + 8'd2, 1'b0));
		// A new line "xyz" ties with "abc" at one, so the peak stays on "abc".
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd23, 1'b1));
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd24, 1'b0));
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd25, 1'b0));
		// A line start on a read leaves the history as it is.
		pending_requests.push_back(make_read(OP_READ_PAIR, 23, 24, 0, 1'b1));
		// A line start on a non-letter still clears the history.
		pending_requests.push_back(make_feed(CHAR_UPPER_A - 8'd1, 1'b1));
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd23, 1'b0));
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd24, 1'b0));
		pending_requests.push_back(make_read(OP_READ_LETTER, 24, 0, 0, 1'b1));
		// Second "xyz" beats the tie and moves the peak.
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd25, 1'b0));
		// The bytes around the two alphabets: 'Z' and 'z' count, the others are skipped.
		pending_requests.push_back(make_feed(CHAR_UPPER_Z, 1'b0));
		pending_requests.push_back(make_feed(CHAR_UPPER_Z + 8'd1, 1'b0));
		pending_requests.push_back(make_feed(CHAR_LOWER_A - 8'd1, 1'b0));
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd26, 1'b0));
		pending_requests.push_back(make_feed(CHAR_LOWER_A + 8'd25, 1'b0));
		pending_requests.push_back(make_read(OP_READ_TRIPLE, 23, 24, 25, 1'b0));
		pending_requests.push_back(make_read(OP_READ_PAIR, 0, 26, 0, 1'b0));
		pending_requests.push_back(make_read(OP_READ_TRIPLE, 0, 0, 31, 1'b0));

		// Random part. Most feeds are text over four letters so that the same cells
		// fill up and the peak keeps moving; the rest use the whole alphabet or any byte.
		repeat (RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				sel = $urandom_range(0, 99);
				if (sel < 70)
					code = letter_char($urandom_range(0, 3));
				else if (sel < 85)
					code = letter_char($urandom_range(0, 25));
				else
					code = 8'($urandom_range(0, 255));
				pending_requests.push_back(make_feed(code, $urandom_range(0, 99) < 8));
			end else begin
				op = op_t'(2'($urandom_range(1, 3)));
				if (pick < 85) begin
					a = $urandom_range(0, 3);
					b = $urandom_range(0, 3);
					c = $urandom_range(0, 3);
				end else if (pick < 95) begin
					a = $urandom_range(0, 25);
					b = $urandom_range(0, 25);
					c = $urandom_range(0, 25);
				end else begin
					a = $urandom_range(0, 31);
					b = $urandom_range(0, 31);
					c = $urandom_range(0, 31);
				end
				pending_requests.push_back(make_read(op, a, b, c, 1'($urandom_range(0, 1))));
			end
		end

		// Reset is held at the start, once.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Checked on the falling edge so that every update of the rising edge has settled.
		while (!stuck && !(pending_requests.size() == 0 && !item_valid &&
				expected_results.size() == 0))
			@(negedge clk);
		if (!stuck)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (stuck || mismatches != 0)
			$display("DONE: errors detected");
		else
			$display("DONE: 0 errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lnh_pkg.sv
rtl/lnh_ram.sv
rtl/letter_ngram_histogram_top.sv
verif/tb_letter_ngram_histogram_top.sv
